/* sv/assert_macros.svh */
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define VFPI_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define VFPI_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");
`else
`define VFPI_ASSERT(label, clk, rst_n, prop)
`define VFPI_ASSERT_RST(label, clk, prop)
`endif
`endif

/* sv/vfpi_pkg.sv */
// Package of types and constants for the velocity filtered PI unit.
`default_nettype none
package vfpi_pkg;

  localparam int ERR_W  = 17;
  localparam int FILT_W = 18;
  localparam int ISUM_W = 24;
  localparam int OPA_W  = 25;
  localparam int OPB_W  = 17;
  localparam int ACC_W  = 42;

  localparam logic signed [OPB_W-1:0] FILT_COEF = 17'sd19661;
  localparam logic signed [OPB_W-1:0] FILT_KEEP = 17'sd45875;
  localparam logic signed [ERR_W-1:0] DEADBAND  = 17'sd128;

  localparam logic [1:0] REG_GAIN_PROP      = 2'd0;
  localparam logic [1:0] REG_GAIN_INTEG     = 2'd1;
  localparam logic [1:0] REG_INTEGRAL_LIMIT = 2'd2;

  localparam logic CMD_STEP  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef struct packed {
    logic               command;
    logic signed [15:0] speed_measured;
    logic signed [15:0] speed_target;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] drive;
    logic               drive_saturated;
  } out_item_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  typedef struct packed {
    acc_op_t acc_op;
  } mac_ctl_t;

endpackage
`default_nettype wire

/* sv/vfpi_mac.sv */
// Shared multiplier with registered product and accumulator.
`default_nettype none
module vfpi_mac (
  input  wire logic                                clk,
  input  wire vfpi_pkg::mac_ctl_t                  ctl,
  input  wire logic signed [vfpi_pkg::OPA_W-1:0]   op_a,
  input  wire logic signed [vfpi_pkg::OPB_W-1:0]   op_b,
  output logic signed [vfpi_pkg::ACC_W-1:0]        acc
);
  import vfpi_pkg::*;

  logic signed [ACC_W-1:0] prod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_nxt;

  always_comb begin
    unique case (ctl.acc_op)
      ACC_LOAD: acc_nxt = prod_r;
      ACC_ADD:  acc_nxt = acc_r + prod_r;
      default:  acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
    acc_r  <= acc_nxt;
  end

  assign acc = acc_r;

endmodule
`default_nettype wire

/* sv/velocity_filtered_pi_unit.sv */
// Top level of the velocity filtered PI unit: sequencer, state and output register.
//
// Input channel in_valid/in_ready/in_data carries one command beat: a control
// step with measured and target speed (Q8.8), or a clear of filter and integral.
// Each beat gives exactly one result beat on out_valid/out_ready/out_data:
// the drive value, truncated toward zero and saturated, with a clip flag.
// A control step runs through states S_ERR, S_KEEP, S_FSUM, S_FILT, S_INTEG,
// S_PROP, S_GINT, S_DSUM and S_OUT; a clear goes straight to S_OUT. One
// multiplier with a registered product is reused for the four products of the
// filter and the PI sum. in_ready is high only while the sequencer is idle, so
// a new beat is taken only after the last one is written back. A finished result
// waits in the output register; the next beat is accepted and computed meanwhile,
// and holds before its write-back until the receiver takes the waiting result.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect at once; the user
// must make them only while idle; the block does not check it. Index 3 is ignored.
// Synchronous reset (rst_n low) zeroes the filter, the integral and the gains,
// sets the integral limit to 32767 and drops any pending result.
`default_nettype none
`include "assert_macros.svh"
module velocity_filtered_pi_unit (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire vfpi_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output vfpi_pkg::out_item_t       out_data,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [15:0]          cfg_wdata
);
  import vfpi_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ERR,
    S_KEEP,
    S_FSUM,
    S_FILT,
    S_INTEG,
    S_PROP,
    S_GINT,
    S_DSUM,
    S_OUT
  } state_t;

  state_t                  state_r;
  logic signed [15:0]      gain_prop_r;
  logic signed [15:0]      gain_integ_r;
  logic [14:0]             limit_r;
  logic signed [FILT_W-1:0] fe_r;
  logic signed [ISUM_W-1:0] isum_r;
  logic signed [ERR_W-1:0] err_r;
  logic                    clear_r;
  logic                    out_valid_r;
  out_item_t               out_r;

  mac_ctl_t                mac_ctl;
  logic signed [OPA_W-1:0] op_a;
  logic signed [OPB_W-1:0] op_b;
  logic signed [ACC_W-1:0] acc;

  logic signed [ERR_W-1:0] err_raw;
  logic signed [ERR_W-1:0] err_db;
  logic signed [ACC_W-1:0] acc_rnd;
  logic signed [ACC_W-1:0] acc_tr;
  logic signed [ACC_W-17:0] drv_full;
  logic signed [ISUM_W:0]  isum_raw;
  logic signed [ISUM_W:0]  lim_pos;
  logic signed [ISUM_W:0]  lim_neg;
  logic signed [ISUM_W-1:0] isum_clamped;
  out_item_t               res;
  logic                    in_fire;
  logic                    out_free;

  vfpi_mac u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .op_a (op_a),
    .op_b (op_b),
    .acc  (acc)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || out_ready;

  assign err_raw = ERR_W'(in_data.speed_measured) - ERR_W'(in_data.speed_target);
  assign err_db  = (err_raw < DEADBAND && err_raw > -DEADBAND) ? '0 : err_raw;

  always_comb begin
    op_a           = OPA_W'(err_r);
    op_b           = FILT_COEF;
    mac_ctl.acc_op = ACC_HOLD;
    unique case (state_r)
      S_ERR: begin
        op_a = OPA_W'(err_r);
        op_b = FILT_COEF;
      end
      S_KEEP: begin
        op_a           = OPA_W'(fe_r);
        op_b           = FILT_KEEP;
        mac_ctl.acc_op = ACC_LOAD;
      end
      S_FSUM:  mac_ctl.acc_op = ACC_ADD;
      S_PROP: begin
        op_a = OPA_W'(fe_r);
        op_b = OPB_W'(gain_prop_r);
      end
      S_GINT: begin
        op_a           = OPA_W'(isum_r);
        op_b           = OPB_W'(gain_integ_r);
        mac_ctl.acc_op = ACC_LOAD;
      end
      S_DSUM:  mac_ctl.acc_op = ACC_ADD;
      default: mac_ctl.acc_op = ACC_HOLD;
    endcase
  end

  assign acc_rnd = acc + ACC_W'(32768);

  assign isum_raw = (ISUM_W+1)'(isum_r) + (ISUM_W+1)'(fe_r);
  assign lim_pos  = (ISUM_W+1)'({limit_r, 8'd0});
  assign lim_neg  = -lim_pos;

  always_comb begin
    priority if (isum_raw > lim_pos) begin
      isum_clamped = ISUM_W'(lim_pos);
    end else if (isum_raw < lim_neg) begin
      isum_clamped = ISUM_W'(lim_neg);
    end else begin
      isum_clamped = ISUM_W'(isum_raw);
    end
  end

  assign acc_tr   = acc[ACC_W-1] ? (acc + ACC_W'(65535)) : acc;
  assign drv_full = acc_tr[ACC_W-1:16];

  always_comb begin
    res.drive           = drv_full[15:0];
    res.drive_saturated = 1'b0;
    priority if (clear_r) begin
      res.drive = '0;
    end else if (drv_full > (ACC_W-16)'(32767)) begin
      res.drive           = 16'sh7fff;
      res.drive_saturated = 1'b1;
    end else if (drv_full < -(ACC_W-16)'(32768)) begin
      res.drive           = 16'sh8000;
      res.drive_saturated = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      gain_prop_r  <= '0;
      gain_integ_r <= '0;
      limit_r      <= 15'h7fff;
      fe_r         <= '0;
      isum_r       <= '0;
      clear_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_GAIN_PROP:      gain_prop_r  <= cfg_wdata;
          REG_GAIN_INTEG:     gain_integ_r <= cfg_wdata;
          REG_INTEGRAL_LIMIT: limit_r      <= cfg_wdata[14:0];
          default: ;
        endcase
      end
      if (out_valid_r && out_ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            err_r <= err_db;
            if (in_data.command == CMD_CLEAR) begin
              clear_r <= 1'b1;
              fe_r    <= '0;
              isum_r  <= '0;
              state_r <= S_OUT;
            end else begin
              clear_r <= 1'b0;
              state_r <= S_ERR;
            end
          end
        end
        S_ERR:   state_r <= S_KEEP;
        S_KEEP:  state_r <= S_FSUM;
        S_FSUM:  state_r <= S_FILT;
        S_FILT: begin
          fe_r    <= acc_rnd[FILT_W+15:16];
          state_r <= S_INTEG;
        end
        S_INTEG: begin
          isum_r  <= isum_clamped;
          state_r <= S_PROP;
        end
        S_PROP:  state_r <= S_GINT;
        S_GINT:  state_r <= S_DSUM;
        S_DSUM:  state_r <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            out_r       <= res;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `VFPI_ASSERT(a_out_hold, clk, rst_n,
    out_valid && !out_ready |=> out_valid && $stable(out_data))
  `VFPI_ASSERT(a_busy_after_accept, clk, rst_n, in_valid && in_ready |=> !in_ready)
  `VFPI_ASSERT(a_sat_extreme, clk, rst_n,
    out_valid && out_data.drive_saturated |->
      (out_data.drive == 16'sh7fff || out_data.drive == 16'sh8000))
  `VFPI_ASSERT_RST(a_filt_range, clk, !rst_n || fe_r[FILT_W-1] == fe_r[FILT_W-2])

endmodule
`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the velocity filtered PI unit: random handshakes, drive prediction.
module tb_top;
  import vfpi_pkg::*;

  localparam logic [1:0] REG_SPARE = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_GAIN_PROP;
  logic [15:0] cfg_wdata = '0;

  velocity_filtered_pi_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // loop state and settings as the block should hold them
  logic signed [17:0] filt_q88 = '0;
  logic signed [23:0] isum_q = '0;
  logic signed [15:0] gain_p = '0;
  logic signed [15:0] gain_i = '0;
  logic [14:0]        isum_bound = 15'h7FFF;

  in_item_t  beat_backlog[$];
  out_item_t drive_expect[$];
  out_item_t drive_want;

  bit idle_on = 1'b1;
  bit drain_pause = 1'b0;
  int send_gap = 0;
  int take_stall = 0;
  int fail_count = 0;
  int beats_sent = 0;
  int clears_sent = 0;
  int drives_seen = 0;
  int clips_seen = 0;
  int settings_used = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic out_item_t predict_drive(input in_item_t beat);
    logic signed [16:0] err;
    longint acc;
    longint bound;
    longint sum;
    longint drv;
    out_item_t res;
    res = '0;
    if (beat.command == CMD_CLEAR) begin
      filt_q88 = '0;
      isum_q = '0;
      return res;
    end
    err = {beat.speed_measured[15], beat.speed_measured}
        - {beat.speed_target[15], beat.speed_target};
    if (err < DEADBAND && err > -DEADBAND) err = '0;
    acc = longint'(FILT_COEF) * longint'(err) + longint'(FILT_KEEP) * longint'(filt_q88);
    filt_q88 = 18'((acc + 64'sd32768) >>> 16);
    bound = longint'(isum_bound) * 256;
    sum = longint'(isum_q) + longint'(filt_q88);
    if (sum > bound) sum = bound;
    if (sum < -bound) sum = -bound;
    isum_q = 24'(sum);
    acc = longint'(gain_p) * longint'(filt_q88) + longint'(gain_i) * longint'(isum_q);
    drv = (acc >= 0) ? (acc >>> 16) : -((-acc) >>> 16);
    if (drv > 32767) begin
      drv = 32767;
      res.drive_saturated = 1'b1;
    end else if (drv < -32768) begin
      drv = -32768;
      res.drive_saturated = 1'b1;
    end
    res.drive = drv[15:0];
    return res;
  endfunction

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        drive_expect.push_back(predict_drive(in_data));
        beats_sent++;
        if (in_data.command == CMD_CLEAR) clears_sent++;
        if (idle_on && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 18);
        if (idle_on && ($urandom_range(0, 49) == 0 || beats_sent == 60)) drain_pause = 1'b1;
      end
      if (!in_valid || in_ready) begin
        if (drain_pause && drive_expect.size() == 0) drain_pause = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (drain_pause) begin
          in_valid <= 1'b0;
        end else if (beat_backlog.size() > 0) begin
          in_data <= beat_backlog.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (drive_expect.size() == 0) begin
          $display("%0t: unexpected drive beat: expected none, actual drive %0d clip %0b",
                   $time, out_data.drive, out_data.drive_saturated);
          fail_count++;
        end else begin
          drive_want = drive_expect.pop_front();
          drives_seen++;
          if (drive_want.drive_saturated) clips_seen++;
          if (out_data.drive !== drive_want.drive) begin
            $display("%0t: drive mismatch: expected %0d, actual %0d",
                     $time, drive_want.drive, out_data.drive);
            fail_count++;
          end
          if (out_data.drive_saturated !== drive_want.drive_saturated) begin
            $display("%0t: drive_saturated mismatch: expected %0b, actual %0b",
                     $time, drive_want.drive_saturated, out_data.drive_saturated);
            fail_count++;
          end
        end
      end
      if (take_stall > 0) begin
        take_stall--;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        take_stall = $urandom_range(1, 18) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic queue_step(input logic cmd, input logic [15:0] meas, input logic [15:0] tgt);
    in_item_t beat;
    beat.command = cmd;
    beat.speed_measured = meas;
    beat.speed_target = tgt;
    beat_backlog.push_back(beat);
  endtask

  task automatic settle();
    do @(negedge clk);
    while (beat_backlog.size() > 0 || in_valid || drive_expect.size() > 0);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_GAIN_PROP:      gain_p = val;
      REG_GAIN_INTEG:     gain_i = val;
      REG_INTEGRAL_LIMIT: isum_bound = val[14:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_all(input logic [15:0] kp, input logic [15:0] ki, input logic [15:0] lim);
    write_reg(REG_GAIN_PROP, kp);
    write_reg(REG_GAIN_INTEG, ki);
    write_reg(REG_INTEGRAL_LIMIT, lim);
    settings_used++;
  endtask

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 4))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'($urandom_range(0, 2047)) - 16'd1024;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_limit();
    case ($urandom_range(0, 3))
      0:       return {1'($urandom), 15'h0000};
      1:       return {1'($urandom), 15'h7FFF};
      2:       return 16'($urandom_range(0, 300));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_random_step(input int bias);
    int meas;
    int tgt;
    case ($urandom_range(0, 15))
      0: begin
        queue_step(CMD_CLEAR, 16'($urandom), 16'($urandom));
        return;
      end
      1, 2: begin
        meas = $urandom;
        tgt = $urandom;
      end
      3, 4: begin
        meas = $urandom_range(0, 65535) - 32768;
        tgt = meas + $urandom_range(0, 510) - 255;
      end
      5: begin
        meas = $urandom_range(0, 1) ? 32767 : -32768;
        tgt = $urandom_range(0, 1) ? 32767 : -32768;
      end
      default: begin
        meas = $urandom_range(0, 40000) - 20000;
        tgt = meas - bias + $urandom_range(0, 600) - 300;
      end
    endcase
    queue_step(CMD_STEP, 16'(meas), 16'(tgt));
  endtask

  initial begin
    int bias;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: zero gains
    queue_step(CMD_STEP, 16'sd5000, -16'sd3000);
    settle();

    // deadband edges, extreme errors, rounding ties after clear
    write_all(16'h0100, 16'h0040, 16'd100);
    write_reg(REG_SPARE, 16'hFFFF);
    queue_step(CMD_STEP, 16'sd0, 16'sd0);
    queue_step(CMD_STEP, 16'sd127, 16'sd0);
    queue_step(CMD_STEP, 16'sd128, 16'sd0);
    queue_step(CMD_STEP, 16'sd0, 16'sd127);
    queue_step(CMD_STEP, 16'sd0, 16'sd128);
    queue_step(CMD_STEP, 16'sd32767, -16'sd32768);
    queue_step(CMD_STEP, -16'sd32768, 16'sd32767);
    queue_step(CMD_CLEAR, 16'hFFFF, 16'hFFFF);
    queue_step(CMD_STEP, 16'sd32767, -16'sd1);
    queue_step(CMD_CLEAR, 16'h0000, 16'h0000);
    queue_step(CMD_STEP, -16'sd1, 16'sd32767);
    settle();

    // drive clipping both ways
    write_all(16'h7FFF, 16'h7FFF, 16'h7FFF);
    repeat (4) queue_step(CMD_STEP, 16'sd32767, -16'sd32768);
    queue_step(CMD_CLEAR, 16'h0000, 16'h0000);
    repeat (4) queue_step(CMD_STEP, -16'sd32768, 16'sd32767);
    settle();

    // zero limit, most negative gains
    write_all(16'h8000, 16'h8000, 16'h8000);
    repeat (3) queue_step(CMD_STEP, 16'sd32767, -16'sd32768);
    settle();

    for (int phase = 0; phase < 8; phase++) begin
      idle_on = (phase < 6);
      write_all(pick_gain(), pick_gain(), pick_limit());
      if ($urandom_range(0, 2) == 0) write_reg(REG_SPARE, 16'($urandom));
      bias = $urandom_range(0, 8000) - 4000;
      repeat (50) queue_random_step(bias);
      settle();
    end

    repeat (20) @(posedge clk);
    $display("Sent %0d beats (%0d clears) over %0d register settings;", beats_sent,
             clears_sent, settings_used);
    $display("checked %0d drive beats, %0d of them clipped.", drives_seen, clips_seen);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #(4 * 400000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
